[sv/json_string_unescape_decoder_assert.svh]
// Assertion macros used by the decoder's top-level RTL file.
// Each expects clk and rst_n in the scope where it is used.
`ifndef JSON_STRING_UNESCAPE_DECODER_ASSERT_SVH
`define JSON_STRING_UNESCAPE_DECODER_ASSERT_SVH

// Same-cycle implication.
`define JSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/jsu_pkg.sv]
package jsu_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned StatW = 2;

  // Result status codes
  localparam logic [StatW-1:0] ST_BYTE   = 2'd0;
  localparam logic [StatW-1:0] ST_CLOSED = 2'd1;
  localparam logic [StatW-1:0] ST_ERROR  = 2'd2;

  // Up to three result bytes caused by one input transaction
  typedef struct packed {
    logic [1:0]       cnt;     // number of results, 0 to 3
    logic [StatW-1:0] status;
    logic [ByteW-1:0] b0;
    logic [ByteW-1:0] b1;
    logic [ByteW-1:0] b2;
  } jsu_burst_t;

endpackage

[sv/jsu_in_reg.sv]
module jsu_in_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [jsu_pkg::ByteW-1:0] in_byte,
  input  logic                   in_end,
  input  logic                   consume,
  output logic                   item_valid,
  output logic [jsu_pkg::ByteW-1:0] item_byte,
  output logic                   item_end
);
  import jsu_pkg::*;

  logic             valid_r;
  logic [ByteW-1:0] byte_r;
  logic             end_r;

  assign in_tready  = !valid_r || consume;
  assign item_valid = valid_r;
  assign item_byte  = byte_r;
  assign item_end   = end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_byte;
      end_r  <= in_end;
    end
  end

endmodule

[sv/jsu_decode.sv]
module jsu_decode (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [jsu_pkg::ByteW-1:0] item_byte,
  input  logic                      item_end,
  input  logic                      consume,
  output jsu_pkg::jsu_burst_t       burst
);
  import jsu_pkg::*;

  localparam logic [1:0] MODE_WAIT = 2'd0;
  localparam logic [1:0] MODE_STR  = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  logic [1:0]  mode_r, mode_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] cp_r, cp_nxt;
  logic [15:0] cp_full;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic        err;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (item_byte >= 8'h30 && item_byte <= 8'h39) begin
      hex_val = item_byte[3:0];
    end else if ((item_byte >= 8'h61 && item_byte <= 8'h66) ||
                 (item_byte >= 8'h41 && item_byte <= 8'h46)) begin
      hex_val = item_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp_full = {cp_r[11:0], hex_val};

  always_comb begin
    burst       = '0;
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    cp_nxt      = cp_r;
    err         = 1'b0;
    if (item_end) begin
      err = 1'b1;
    end else begin
      unique case (mode_r)
        MODE_WAIT: begin
          if (item_byte != CH_QUOTE) begin
            err = 1'b1;
          end else begin
            mode_nxt = MODE_STR;
          end
        end
        MODE_STR: begin
          if (item_byte == CH_QUOTE) begin
            mode_nxt     = MODE_WAIT;
            burst.cnt    = 2'd1;
            burst.status = ST_CLOSED;
          end else if (item_byte == CH_BSL) begin
            mode_nxt = MODE_ESC;
          end else begin
            burst.cnt = 2'd1;
            burst.b0  = item_byte;
          end
        end
        MODE_ESC: begin
          mode_nxt  = MODE_STR;
          burst.cnt = 2'd1;
          unique case (item_byte)
            CH_QUOTE, CH_BSL, CH_SLASH: burst.b0 = item_byte;
            CH_B: burst.b0 = 8'h08;
            CH_F: burst.b0 = 8'h0C;
            CH_N: burst.b0 = 8'h0A;
            CH_R: burst.b0 = 8'h0D;
            CH_T: burst.b0 = 8'h09;
            CH_U: begin
              burst.cnt   = 2'd0;
              mode_nxt    = MODE_HEX;
              hex_cnt_nxt = 2'd0;
              cp_nxt      = 16'd0;
            end
            default: err = 1'b1;
          endcase
        end
        MODE_HEX: begin
          if (!hex_ok) begin
            err = 1'b1;
          end else if (hex_cnt_r == 2'd3) begin
            mode_nxt    = MODE_STR;
            hex_cnt_nxt = 2'd0;
            cp_nxt      = 16'd0;
            if (cp_full < 16'h0080) begin
              burst.cnt = 2'd1;
              burst.b0  = cp_full[7:0];
            end else if (cp_full < 16'h0800) begin
              burst.cnt = 2'd2;
              burst.b0  = 8'hC0 | {3'd0, cp_full[10:6]};
              burst.b1  = 8'h80 | {2'd0, cp_full[5:0]};
            end else begin
              burst.cnt = 2'd3;
              burst.b0  = 8'hE0 | {4'd0, cp_full[15:12]};
              burst.b1  = 8'h80 | {2'd0, cp_full[11:6]};
              burst.b2  = 8'h80 | {2'd0, cp_full[5:0]};
            end
          end else begin
            cp_nxt      = cp_full;
            hex_cnt_nxt = hex_cnt_r + 2'd1;
          end
        end
        default: err = 1'b1;
      endcase
    end
    if (err) begin
      burst        = '0;
      burst.cnt    = 2'd1;
      burst.status = ST_ERROR;
      mode_nxt     = MODE_WAIT;
      hex_cnt_nxt  = 2'd0;
      cp_nxt       = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_WAIT;
      hex_cnt_r <= 2'd0;
      cp_r      <= 16'd0;
    end else if (consume) begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      cp_r      <= cp_nxt;
    end
  end

endmodule

[sv/jsu_out_burst.sv]
module jsu_out_burst (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  jsu_pkg::jsu_burst_t       burst,
  output logic                      free,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [jsu_pkg::ByteW-1:0] out_byte,
  output logic [jsu_pkg::StatW-1:0] out_status,
  output logic                      out_tlast,
  output logic [1:0]                held_cnt
);
  import jsu_pkg::*;

  logic       valid_r, valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  jsu_burst_t burst_r;
  logic       take;

  assign out_tvalid = valid_r;
  assign out_tlast  = (idx_r == burst_r.cnt - 2'd1);
  assign out_status = burst_r.status;
  assign held_cnt   = burst_r.cnt;
  assign take       = valid_r && out_tready;
  // empty, or the final byte of the held burst leaves this cycle
  assign free       = !valid_r || (out_tready && out_tlast);

  always_comb begin
    unique case (idx_r)
      2'd0:    out_byte = burst_r.b0;
      2'd1:    out_byte = burst_r.b1;
      default: out_byte = burst_r.b2;
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = 2'd0;
    end else if (take) begin
      if (out_tlast) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst_r <= burst;
    end
  end

endmodule

[sv/json_string_unescape_decoder.sv]
// JSON string unescape decoder.
// Input channel in_*: one byte of a quoted JSON string per transaction in
// in_tdata; in_tuser set marks the end of input (no byte carried, gives an
// error result). Output channel out_*: decoded bytes in out_tdata, status
// in out_tuser (byte, string closed, syntax error); out_tlast marks the
// final result caused by one input transaction.
// The first result of an accepted input transaction passes through the input
// register and then the output register before it shows on out_*.
// Throughput: one input transaction per cycle while each gives at most one
// result and the receiver does not stall; a \u escape giving a two- or
// three-byte UTF-8 sequence holds the input until the single output register,
// which hands the burst out one byte per cycle while out_tready is high, is free.
// The opening quote, backslash, 'u' and the first three hex digits give no
// result and never wait on the output side.
// Reset (rst_n low, synchronous) empties both registers and returns the
// decoder to waiting for an opening quote.
// When the receiver stalls, the result holds on out_* and the input register
// keeps one further transaction before in_tready drops.
module json_string_unescape_decoder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic [0:0] in_tuser,   // [0] stream_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] status
  output logic       out_tlast
);
  import jsu_pkg::*;

  `include "json_string_unescape_decoder_assert.svh"

  logic             item_valid;
  logic [ByteW-1:0] item_byte;
  logic             item_end;
  jsu_burst_t       burst;
  logic             out_free;
  logic             consume;
  logic             load;
  logic [1:0]       held_cnt;

  // Advance the held item when it gives no result, or when the output
  // register can take its burst this cycle.
  assign consume = item_valid && ((burst.cnt == 2'd0) || out_free);
  assign load    = consume && (burst.cnt != 2'd0);

  jsu_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_byte    (in_tdata),
    .in_end     (in_tuser[0]),
    .consume    (consume),
    .item_valid (item_valid),
    .item_byte  (item_byte),
    .item_end   (item_end)
  );

  jsu_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_byte (item_byte),
    .item_end  (item_end),
    .consume   (consume),
    .burst     (burst)
  );

  jsu_out_burst u_out_burst (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .burst      (burst),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_status (out_tuser),
    .out_tlast  (out_tlast),
    .held_cnt   (held_cnt)
  );

  `JSU_ASSERT_NOW(a_burst_nonempty, out_tvalid, held_cnt != 2'd0, "empty burst presented")
  `JSU_ASSERT_NOW(a_status_single, out_tvalid && (out_tuser != ST_BYTE), (out_tdata == 8'd0) && out_tlast, "status result not a lone zero byte")
  `JSU_ASSERT_NEXT(a_item_held, item_valid && !consume, item_valid && $stable(item_byte) && $stable(item_end), "input item lost while waiting")

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

// Self-checking bench for the JSON string unescape decoder.
// A directed table walks the error paths, byte extremes and two- and three-byte
// UTF-8 forms, then random quoted strings (mostly well formed, some broken) follow.
// Every accepted input transaction advances a local decoder model; its results,
// or a typed row's own expectation, queue up and are compared with each output in order.
module testbench;
  import jsu_pkg::*;

  localparam logic [7:0] QUOTE  = 8'h22;
  localparam logic [7:0] BSLASH = 8'h5C;
  localparam logic [7:0] SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_U = 8'h75;

  // Characters that may follow a backslash, apart from 'u'
  localparam logic [7:0] ESCAPE_CHARS [8] = '{
    QUOTE, BSLASH, SLASH, 8'h62, 8'h66, 8'h6E, 8'h72, 8'h74
  };

  localparam int unsigned ITEM_TARGET     = 310;
  localparam int unsigned CYCLE_LIMIT     = 50000;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned HOLD_OFF_CYCLES = 48;
  localparam int unsigned HOLD_OFF_ITEM   = 60;
  localparam int unsigned CALM_FIRST      = 120;
  localparam int unsigned CALM_LAST       = 200;

  typedef enum logic [1:0] {
    WAIT_OPEN, IN_STRING, AFTER_BSLASH, IN_HEX
  } dec_mode_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [StatW-1:0] status;
    logic             last;
  } dec_result_t;

  // One input transaction. Rows with typed set carry their own expectation:
  // either nothing, or one result that is also the last of the transaction.
  typedef struct packed {
    logic [7:0]       char_in;
    logic             stream_end;
    logic             typed;
    logic             typed_gives;
    logic [7:0]       typed_data;
    logic [StatW-1:0] typed_status;
  } stim_t;

  localparam stim_t DIRECTED [29] = '{
    // in_tdata  end   typed gives  data   status
    '{8'h5A,  1'b1, 1'b1, 1'b1, 8'h00, ST_ERROR },  // input ends while waiting
    '{8'h41,  1'b0, 1'b1, 1'b1, 8'h00, ST_ERROR },  // wrong opening byte
    '{QUOTE,  1'b0, 1'b1, 1'b0, 8'h00, ST_BYTE  },  // open
    '{8'h00,  1'b0, 1'b1, 1'b1, 8'h00, ST_BYTE  },  // lowest raw byte
    '{8'hFF,  1'b0, 1'b1, 1'b1, 8'hFF, ST_BYTE  },  // highest raw byte
    '{BSLASH, 1'b0, 1'b1, 1'b0, 8'h00, ST_BYTE  },
    '{8'h6E,  1'b0, 1'b1, 1'b1, 8'h0A, ST_BYTE  },  // \n
    '{BSLASH, 1'b0, 1'b1, 1'b0, 8'h00, ST_BYTE  },  // \uFffF: three bytes
    '{CHAR_U, 1'b0, 1'b1, 1'b0, 8'h00, ST_BYTE  },
    '{8'h46,  1'b0, 1'b1, 1'b0, 8'h00, ST_BYTE  },
    '{8'h66,  1'b0, 1'b1, 1'b0, 8'h00, ST_BYTE  },
    '{8'h66,  1'b0, 1'b1, 1'b0, 8'h00, ST_BYTE  },
    '{8'h46,  1'b0, 1'b0, 1'b0, 8'h00, ST_BYTE  },
    '{BSLASH, 1'b0, 1'b1, 1'b0, 8'h00, ST_BYTE  },  // \u07Ff: two bytes
    '{CHAR_U, 1'b0, 1'b1, 1'b0, 8'h00, ST_BYTE  },
    '{8'h30,  1'b0, 1'b1, 1'b0, 8'h00, ST_BYTE  },
    '{8'h37,  1'b0, 1'b1, 1'b0, 8'h00, ST_BYTE  },
    '{8'h46,  1'b0, 1'b1, 1'b0, 8'h00, ST_BYTE  },
    '{8'h66,  1'b0, 1'b0, 1'b0, 8'h00, ST_BYTE  },
    '{BSLASH, 1'b0, 1'b1, 1'b0, 8'h00, ST_BYTE  },
    '{8'h71,  1'b0, 1'b1, 1'b1, 8'h00, ST_ERROR },  // unknown escape
    '{QUOTE,  1'b0, 1'b1, 1'b0, 8'h00, ST_BYTE  },
    '{BSLASH, 1'b0, 1'b1, 1'b0, 8'h00, ST_BYTE  },
    '{CHAR_U, 1'b0, 1'b1, 1'b0, 8'h00, ST_BYTE  },
    '{8'h67,  1'b0, 1'b1, 1'b1, 8'h00, ST_ERROR },  // bad hex digit
    '{QUOTE,  1'b0, 1'b1, 1'b0, 8'h00, ST_BYTE  },
    '{QUOTE,  1'b0, 1'b1, 1'b1, 8'h00, ST_CLOSED},  // empty string closes
    '{QUOTE,  1'b0, 1'b1, 1'b0, 8'h00, ST_BYTE  },
    '{8'hA5,  1'b1, 1'b1, 1'b1, 8'h00, ST_ERROR }   // input ends inside string
  };

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [7:0]       in_tdata;
  logic [0:0]       in_tuser;
  logic             out_tvalid;
  logic             out_tready;
  logic [7:0]       out_tdata;
  logic [StatW-1:0] out_tuser;
  logic             out_tlast;

  // Local decoder state
  dec_mode_t   pred_mode      = WAIT_OPEN;
  logic [1:0]  pred_hex_count = '0;
  logic [15:0] pred_code      = '0;
  dec_result_t step_out [3];

  stim_t       stim_q [$];
  dec_result_t decoded_q [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          stimulus_done  = 1'b0;
  bit          calm           = 1'b0;
  bit          hold_off_req   = 1'b0;
  bit          hold_off_done  = 1'b0;

  json_string_unescape_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Value of a hex digit, or -1 for any other byte
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return 8'h30 + v;
    return (upper ? 8'h41 : 8'h61) + v - 8'd10;
  endfunction

  // Append one result to step_out and advance the count
  function automatic void add_result(inout int n, input dec_result_t r);
    step_out[n] = r;
    n++;
  endfunction

  // Advance the local decoder by one transaction; fill step_out and return
  // how many results the transaction gives.
  function automatic int decode_step(input logic [7:0] c, input logic ended);
    int          n;
    int          nib;
    bit          bad;
    logic [15:0] cp;
    n   = 0;
    bad = 1'b0;
    if (ended) begin
      bad = 1'b1;
    end else begin
      case (pred_mode)
        WAIT_OPEN: begin
          if (c != QUOTE) bad = 1'b1;
          else pred_mode = IN_STRING;
        end
        IN_STRING: begin
          if (c == QUOTE) begin
            pred_mode = WAIT_OPEN;
            add_result(n, '{8'h00, ST_CLOSED, 1'b0});
          end else if (c == BSLASH) begin
            pred_mode = AFTER_BSLASH;
          end else begin
            add_result(n, '{c, ST_BYTE, 1'b0});
          end
        end
        AFTER_BSLASH: begin
          pred_mode = IN_STRING;
          case (c)
            QUOTE, BSLASH, SLASH: add_result(n, '{c, ST_BYTE, 1'b0});
            8'h62: add_result(n, '{8'h08, ST_BYTE, 1'b0});
            8'h66: add_result(n, '{8'h0C, ST_BYTE, 1'b0});
            8'h6E: add_result(n, '{8'h0A, ST_BYTE, 1'b0});
            8'h72: add_result(n, '{8'h0D, ST_BYTE, 1'b0});
            8'h74: add_result(n, '{8'h09, ST_BYTE, 1'b0});
            CHAR_U: begin
              pred_mode      = IN_HEX;
              pred_hex_count = '0;
              pred_code      = '0;
            end
            default: bad = 1'b1;
          endcase
        end
        default: begin
          nib = hex_nibble(c);
          if (nib < 0) begin
            bad = 1'b1;
          end else begin
            cp = {pred_code[11:0], nib[3:0]};
            if (pred_hex_count == 2'd3) begin
              // Encode the finished code point as one to three UTF-8 bytes
              if (cp < 16'h0080) begin
                add_result(n, '{cp[7:0], ST_BYTE, 1'b0});
              end else if (cp < 16'h0800) begin
                add_result(n, '{{3'b110, cp[10:6]}, ST_BYTE, 1'b0});
                add_result(n, '{{2'b10, cp[5:0]}, ST_BYTE, 1'b0});
              end else begin
                add_result(n, '{{4'b1110, cp[15:12]}, ST_BYTE, 1'b0});
                add_result(n, '{{2'b10, cp[11:6]}, ST_BYTE, 1'b0});
                add_result(n, '{{2'b10, cp[5:0]}, ST_BYTE, 1'b0});
              end
              pred_mode      = IN_STRING;
              pred_hex_count = '0;
              pred_code      = '0;
            end else begin
              pred_code      = cp;
              pred_hex_count = pred_hex_count + 2'd1;
            end
          end
        end
      endcase
    end
    // Any error drops back to waiting and clears the escape state
    if (bad) begin
      pred_mode      = WAIT_OPEN;
      pred_hex_count = '0;
      pred_code      = '0;
      add_result(n, '{8'h00, ST_ERROR, 1'b0});
    end
    if (n > 0) step_out[n-1].last = 1'b1;
    return n;
  endfunction

  // Record an accepted input transaction: advance the model and queue what
  // the block must produce for it.
  task automatic take_transaction(input stim_t s);
    int          n;
    dec_result_t r;
    n = decode_step(s.char_in, s.stream_end);
    if (s.typed) begin
      if (s.typed_gives) begin
        r = '{s.typed_data, s.typed_status, 1'b1};
        decoded_q.insert(decoded_q.size(), r);
      end
    end else begin
      for (int k = 0; k < n; k++) decoded_q.insert(decoded_q.size(), step_out[k]);
    end
  endtask

  function automatic void push_item(input logic [7:0] c, input logic ended);
    stim_t s;
    s = '{c, ended, 1'b0, 1'b0, 8'h00, ST_BYTE};
    stim_q.insert(stim_q.size(), s);
  endfunction

  // Random quoted strings, every one starting from the waiting state: most
  // are well formed with random content, the rest stray bytes, bad escapes,
  // bad hex digits and input cut off in every mode.
  task automatic build_random_stimulus();
    logic [7:0]  c;
    logic [15:0] cp;
    int unsigned good;
    bit          hit;
    while (stim_q.size() < ITEM_TARGET) begin
      if ($urandom_range(99) < 80) begin
        push_item(QUOTE, 1'b0);
        repeat ($urandom_range(8)) begin
          case ($urandom_range(2))
            0: begin
              do c = 8'($urandom_range(255)); while (c == QUOTE || c == BSLASH);
              push_item(c, 1'b0);
            end
            1: begin
              push_item(BSLASH, 1'b0);
              push_item(ESCAPE_CHARS[3'($urandom_range(7))], 1'b0);
            end
            default: begin
              // Spread code points over the one-, two- and three-byte forms
              case ($urandom_range(2))
                0:       cp = 16'($urandom_range(16'h007F));
                1:       cp = 16'($urandom_range(16'h07FF, 16'h0080));
                default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
              endcase
              push_item(BSLASH, 1'b0);
              push_item(CHAR_U, 1'b0);
              for (int k = 3; k >= 0; k--)
                push_item(hex_char(cp[4*k +: 4], 1'($urandom_range(1))), 1'b0);
            end
          endcase
        end
        // Now and then cut the string off instead of closing it
        if ($urandom_range(9) == 0) push_item(8'($urandom_range(255)), 1'b1);
        else push_item(QUOTE, 1'b0);
      end else begin
        case ($urandom_range(3))
          0: begin
            do c = 8'($urandom_range(255)); while (c == QUOTE);
            push_item(c, 1'b0);
          end
          1: push_item(8'($urandom_range(255)), 1'b1);
          2: begin
            push_item(QUOTE, 1'b0);
            push_item(BSLASH, 1'b0);
            if ($urandom_range(1)) begin
              do begin
                c   = 8'($urandom_range(255));
                hit = (c == CHAR_U);
                foreach (ESCAPE_CHARS[k]) if (c == ESCAPE_CHARS[k]) hit = 1'b1;
              end while (hit);
              push_item(c, 1'b0);
            end else begin
              push_item(8'($urandom_range(255)), 1'b1);
            end
          end
          default: begin
            push_item(QUOTE, 1'b0);
            push_item(BSLASH, 1'b0);
            push_item(CHAR_U, 1'b0);
            good = $urandom_range(3);
            repeat (good)
              push_item(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))), 1'b0);
            if ($urandom_range(1)) begin
              do c = 8'($urandom_range(255)); while (hex_nibble(c) >= 0);
              push_item(c, 1'b0);
            end else begin
              push_item(8'($urandom_range(255)), 1'b1);
            end
          end
        endcase
      end
    end
  endtask

  // Idle roughly 9 times in a hundred, never inside the calm window
  function automatic bit take_gap();
    return !calm && ($urandom_range(99) < 9);
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Sender: offer the table, then the random strings, one transaction per
  // handshake, with random gaps between them.
  initial begin : drive_input
    stim_t s;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    foreach (DIRECTED[k]) stim_q.insert(stim_q.size(), DIRECTED[k]);
    build_random_stimulus();
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    for (int idx = 0; idx < stim_q.size(); idx++) begin
      calm = (idx >= CALM_FIRST && idx < CALM_LAST);
      // Ask the receiver for its long hold-off while input keeps coming
      if (idx == HOLD_OFF_ITEM) hold_off_req = 1'b1;
      s = stim_q[idx];
      in_tvalid <= 1'b1;
      in_tdata  <= s.char_in;
      in_tuser  <= s.stream_end;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      take_transaction(s);
      // Keep tvalid high into the next transaction unless a gap is taken
      if (take_gap()) begin
        in_tvalid <= 1'b0;
        in_tdata  <= 8'($urandom_range(255));
        do @(posedge clk); while (take_gap());
      end
    end
    in_tvalid     <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off that fills the block
  initial begin : drive_output_ready
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_tready    <= 1'b0;
        hold_off_done = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_tready <= !take_gap();
      end
    end
  end

  // Compare each output transaction with the oldest expected result
  always @(posedge clk) begin : check_output
    dec_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (decoded_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: data 0x%02h status %0d last %0d",
                                out_tdata, out_tuser, out_tlast));
      end else begin
        want = decoded_q.pop_front();
        if (out_tdata !== want.data)
          flag_mismatch($sformatf("out_tdata 0x%02h, expected 0x%02h", out_tdata, want.data));
        if (out_tuser !== want.status)
          flag_mismatch($sformatf("out_tuser %0d, expected %0d", out_tuser, want.status));
        if (out_tlast !== want.last)
          flag_mismatch($sformatf("out_tlast %0d, expected %0d", out_tlast, want.last));
      end
    end
  end

  // Watchdog: stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Reset once, then wait for the stimulus and all results to drain
  initial begin : run_control
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done);
    while (decoded_q.size() != 0) @(posedge clk);
    // Let any stray result past the last expected one show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
